// ----- rtl/lfss_pkg.sv -----
// Shared types, constants and a helper for the line fixed-string search core.
`default_nettype none

package lfss_pkg;

  // Default window depth and fixed field widths
  localparam int LFSS_PATTERN_MAX = 32;
  localparam int LFSS_LEN_W       = 6;
  localparam int LFSS_WORD_W      = 64;
  localparam int LFSS_WORDS       = 4;
  localparam int LFSS_WORD_BYTES  = 32;
  localparam int LFSS_CFG_IDX_W   = 4;
  localparam int LFSS_COUNT_W     = 32;
  localparam int LFSS_OUT_DATA_W  = 72;

  localparam logic [7:0] LFSS_NEWLINE = 8'h0A;
  localparam logic [LFSS_COUNT_W-1:0] LFSS_COUNT_MAX = '1;

  typedef enum logic {
    LFSS_OP_TEXT = 1'b0,
    LFSS_OP_END  = 1'b1
  } lfss_op_t;

  typedef enum logic {
    LFSS_KIND_VERDICT = 1'b0,
    LFSS_KIND_SUMMARY = 1'b1
  } lfss_kind_t;

  typedef enum logic [LFSS_CFG_IDX_W-1:0] {
    LFSS_REG_LENGTH = 4'd0,
    LFSS_REG_WORD_A = 4'd1,
    LFSS_REG_WORD_B = 4'd2,
    LFSS_REG_WORD_C = 4'd3,
    LFSS_REG_WORD_D = 4'd4,
    LFSS_REG_ICASE  = 4'd5,
    LFSS_REG_INVERT = 4'd6,
    LFSS_REG_STOP   = 4'd7
  } lfss_reg_t;

  // One result item
  typedef struct packed {
    lfss_kind_t              kind;
    logic [LFSS_COUNT_W-1:0] line_number;
    logic                    selected;
    logic [LFSS_COUNT_W-1:0] selected_total;
    logic                    any_selected;
    logic                    last;
  } lfss_result_t;

  // Control from the line tracker to the window scanner
  typedef struct packed {
    logic step;
    logic clear;
  } lfss_scan_ctrl_t;

  // Status from the window scanner
  typedef struct packed {
    logic has_match;
    logic fill_nonzero;
    logic len_zero;
  } lfss_scan_status_t;

  // Fold ASCII lower case onto upper case when enabled
  function automatic logic [7:0] lfss_fold(input logic [7:0] c, input logic icase);
    logic [7:0] r;
    r = c;
    if (icase && c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lfss_scan.sv -----
// Sliding byte window of the current line with parallel pattern comparators.
`default_nettype none

module lfss_scan import lfss_pkg::*; #(
  parameter int PATTERN_MAX = LFSS_PATTERN_MAX
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lfss_scan_ctrl_t                       ctrl,
  input  wire logic [7:0]                            text_byte,
  input  wire logic [LFSS_LEN_W-1:0]                 pattern_length,
  input  wire logic [LFSS_WORDS-1:0][LFSS_WORD_W-1:0] pattern_word,
  input  wire logic                                  ignore_case,
  output lfss_scan_status_t                          status
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (LW > LFSS_LEN_W) ? LW : LFSS_LEN_W;
  localparam int SW = LW + 1;

  logic [LFSS_WORDS*LFSS_WORD_W-1:0] flat;
  logic [7:0] pat_f [PATTERN_MAX];
  logic [7:0] aligned [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] eq;
  logic [7:0] win [PATTERN_MAX];
  logic [7:0] win_next [PATTERN_MAX];
  logic [LW-1:0] fill;
  logic [LW-1:0] fill_next;
  logic [LW-1:0] eff_len;
  logic [LW-1:0] offset;
  logic has_match;
  logic match_now;

  assign flat = pattern_word;

  // Clamp the pattern length to the window depth
  always_comb begin
    if (CW'(pattern_length) > CW'(PATTERN_MAX)) begin
      eff_len = LW'(PATTERN_MAX);
    end else begin
      eff_len = LW'(pattern_length);
    end
  end

  assign offset = LW'(PATTERN_MAX) - eff_len;

  // Unpack and fold pattern bytes; bytes past the packed words read zero
  for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_pat
    if (gi < LFSS_WORD_BYTES) begin : g_word
      assign pat_f[gi] = lfss_fold(flat[8*gi +: 8], ignore_case);
    end else begin : g_zero
      assign pat_f[gi] = lfss_fold(8'h00, ignore_case);
    end
  end

  // Line the pattern up with the newest end of the window
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      aligned[j] = '0;
      in_use[j]  = SW'(j) >= SW'(offset);
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (SW'(i) + SW'(offset) == SW'(j)) begin
          aligned[j] = pat_f[i];
        end
      end
    end
  end

  // Shift the new byte in at the newest end
  always_comb begin
    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
      win_next[j] = win[j + 1];
    end
    win_next[PATTERN_MAX-1] = text_byte;
  end

  assign fill_next = (fill == LW'(PATTERN_MAX)) ? fill : fill + LW'(1);

  // Compare every window position in use against the aligned pattern
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      eq[j] = !in_use[j] || (lfss_fold(win_next[j], ignore_case) == aligned[j]);
    end
  end

  assign match_now = (fill_next >= eff_len) && (&eq);

  // Hold the window contents
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      win <= win_next;
    end
  end

  // Track the line fill and the sticky match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      has_match <= 1'b0;
    end else if (ctrl.clear) begin
      fill      <= '0;
      has_match <= 1'b0;
    end else if (ctrl.step) begin
      fill      <= fill_next;
      has_match <= has_match | match_now;
    end
  end

  assign status.has_match    = has_match;
  assign status.fill_nonzero = (fill != '0);
  assign status.len_zero     = (eff_len == '0);

endmodule

`default_nettype wire

// ----- rtl/line_fixed_string_search_core.sv -----
// Top level of the line fixed-string search core: handshakes, line counters, result queue.
`default_nettype none

// Text bytes enter on the s_ stream, one per cycle while s_tready is high, with tuser marking
// end of input. Each newline (byte 10) yields one line verdict unless stop on first has
// halted the core; end of input likewise closes an unterminated line with a verdict, then
// gives a summary, after which the line and count state is cleared (the configuration
// registers keep their values). A byte is registered at the input, judged by the window
// comparators and lands in a two-entry result queue. Items without results never wait; an
// item is held only while the queue lacks room for its results, so an end of input that
// needs two results waits for an empty queue, and a stalled m_ side holds the next item with
// results once the queue is full. The user writes configuration via cfg_ (always ready) only
// while the block is idle (not enforced by the core); indexes past the list are ignored.
module line_fixed_string_search_core import lfss_pkg::*; #(
  parameter int PATTERN_MAX = LFSS_PATTERN_MAX
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [7:0] text_byte
  input  wire logic                        s_tuser,   // [0] opcode
  // Result stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [31:0] line_number, [32] selected, [64:33] selected_total, [65] any_selected,
  // [71:66] zero
  output logic [LFSS_OUT_DATA_W-1:0]       m_tdata,
  output logic                             m_tuser,   // [0] kind
  output logic                             m_tlast,
  // Configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [LFSS_CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [LFSS_WORD_W-1:0]      cfg_data
);

  // Configuration registers
  logic [LFSS_LEN_W-1:0]                  pattern_length;
  logic [LFSS_WORDS-1:0][LFSS_WORD_W-1:0] pattern_word;
  logic                                   ignore_case;
  logic                                   invert_selection;
  logic                                   stop_on_first;

  // Input register
  logic       in_valid;
  lfss_op_t   in_op;
  logic [7:0] in_byte;

  // Line state
  logic [LFSS_COUNT_W-1:0] lines_seen;
  logic [LFSS_COUNT_W-1:0] selected_count;
  logic                    halted;

  // Result queue
  lfss_result_t q0;
  lfss_result_t q1;
  logic [1:0]   q_count;
  logic [1:0]   q_count_next;
  logic [1:0]   q_rem;
  lfss_result_t q0_next;
  lfss_result_t q1_next;
  lfss_result_t q_head;

  // Judgment of the registered item
  lfss_scan_ctrl_t         scan_ctrl;
  lfss_scan_status_t       scan_status;
  logic                    is_end;
  logic                    is_nl;
  logic                    do_close;
  logic                    do_step;
  logic                    matched;
  logic                    sel;
  logic [LFSS_COUNT_W-1:0] lines_inc;
  logic [LFSS_COUNT_W-1:0] count_inc;
  logic [LFSS_COUNT_W-1:0] lines_c;
  logic [LFSS_COUNT_W-1:0] count_c;
  lfss_result_t            verdict;
  lfss_result_t            summary;
  lfss_result_t            r0;
  logic [1:0]              n_push;
  logic                    proc_fire;
  logic                    pop;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      pattern_word     <= '0;
      ignore_case      <= 1'b0;
      invert_selection <= 1'b0;
      stop_on_first    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        LFSS_REG_LENGTH: pattern_length   <= cfg_data[LFSS_LEN_W-1:0];
        LFSS_REG_WORD_A: pattern_word[0]  <= cfg_data;
        LFSS_REG_WORD_B: pattern_word[1]  <= cfg_data;
        LFSS_REG_WORD_C: pattern_word[2]  <= cfg_data;
        LFSS_REG_WORD_D: pattern_word[3]  <= cfg_data;
        LFSS_REG_ICASE:  ignore_case      <= cfg_data[0];
        LFSS_REG_INVERT: invert_selection <= cfg_data[0];
        LFSS_REG_STOP:   stop_on_first    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the registered item
  assign is_end   = (in_op == LFSS_OP_END);
  assign is_nl    = (in_byte == LFSS_NEWLINE);
  assign do_close = !halted && (is_end ? scan_status.fill_nonzero : is_nl);
  assign do_step  = !halted && !is_end && !is_nl;

  // Judge the line and advance saturating counters
  assign matched   = scan_status.has_match || scan_status.len_zero;
  assign sel       = matched ^ invert_selection;
  assign lines_inc = (lines_seen == LFSS_COUNT_MAX) ? lines_seen : lines_seen + 1'b1;
  assign count_inc = (selected_count == LFSS_COUNT_MAX) ? selected_count
                                                        : selected_count + 1'b1;
  assign lines_c   = do_close ? lines_inc : lines_seen;
  assign count_c   = (do_close && sel) ? count_inc : selected_count;

  // Build the results
  always_comb begin
    verdict.kind           = LFSS_KIND_VERDICT;
    verdict.line_number    = lines_c;
    verdict.selected       = sel;
    verdict.selected_total = count_c;
    verdict.any_selected   = (count_c != '0);
    verdict.last           = !is_end;

    summary.kind           = LFSS_KIND_SUMMARY;
    summary.line_number    = lines_c;
    summary.selected       = 1'b0;
    summary.selected_total = count_c;
    summary.any_selected   = (count_c != '0);
    summary.last           = 1'b1;
  end

  assign r0     = do_close ? verdict : summary;
  assign n_push = is_end ? (do_close ? 2'd2 : 2'd1) : (do_close ? 2'd1 : 2'd0);

  // Advance the item only when the queue has room for all its results
  assign proc_fire = in_valid && (n_push <= (2'd2 - q_count));
  assign s_tready  = !in_valid || proc_fire;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= lfss_op_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  // Update line counters and the halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      lines_seen     <= '0;
      selected_count <= '0;
      halted         <= 1'b0;
    end else if (proc_fire) begin
      if (is_end) begin
        lines_seen     <= '0;
        selected_count <= '0;
        halted         <= 1'b0;
      end else if (do_close) begin
        lines_seen     <= lines_c;
        selected_count <= count_c;
        if (sel && stop_on_first) begin
          halted <= 1'b1;
        end
      end
    end
  end

  // Drive the window scanner
  assign scan_ctrl.step  = proc_fire && do_step;
  assign scan_ctrl.clear = proc_fire && (do_close || is_end);

  lfss_scan #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (scan_ctrl),
    .text_byte      (in_byte),
    .pattern_length (pattern_length),
    .pattern_word   (pattern_word),
    .ignore_case    (ignore_case),
    .status         (scan_status)
  );

  // Queue: drop the head on transfer, append new results behind what remains
  assign pop   = m_tvalid && m_tready;
  assign q_rem = q_count - {1'b0, pop};

  always_comb begin
    q_head       = pop ? q1 : q0;
    q0_next      = q_head;
    q1_next      = q1;
    q_count_next = q_rem;
    if (proc_fire) begin
      q_count_next = q_rem + n_push;
      if (q_rem == 2'd0) begin
        q0_next = r0;
        q1_next = summary;
      end else if (q_rem == 2'd1) begin
        q1_next = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  // Present the head of the queue
  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = {6'b0, q0.any_selected, q0.selected_total, q0.selected, q0.line_number};
  assign m_tuser  = q0.kind;
  assign m_tlast  = q0.last;

`ifndef SYNTH
  // The queue never holds more than two results
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("result queue overflow");

  // A summary always closes the results of its item
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == LFSS_KIND_SUMMARY) |-> m_tlast)
    else $error("summary without last");

  // End of input clears the halt flag and the counters
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    proc_fire && is_end |=> !halted && (lines_seen == '0) && (selected_count == '0))
    else $error("state not cleared after end of input");

  // A held item keeps its byte until it is judged
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc_fire |=> in_valid && $stable(in_byte) && $stable(in_op))
    else $error("input register lost an item");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the line fixed-string search core.
module tb_top import lfss_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL    = 1800;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 10;
  localparam int IDLE_LIMIT   = 2000;

  // One row of the directed sequence: a register write or an input item
  typedef struct packed {
    logic         is_cfg;
    lfss_reg_t    reg_idx;
    logic [63:0]  value;
    lfss_op_t     op;
    logic [7:0]   text_b;
    logic         typed;
    lfss_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
  logic        s_tuser = 1'b0;    // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [31:0] line_number, [32] selected, [64:33] selected_total, [65] any_selected
  logic [LFSS_OUT_DATA_W-1:0] m_tdata;
  logic        m_tuser;           // [0] kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [LFSS_CFG_IDX_W-1:0] cfg_index = '0;
  logic [LFSS_WORD_W-1:0]    cfg_data = '0;

  line_fixed_string_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the search registers
  logic [5:0]  cfg_len;
  logic [63:0] cfg_word [LFSS_WORDS];
  logic        cfg_icase;
  logic        cfg_invert;
  logic        cfg_stop;

  // Line scanner state
  logic [7:0]  win_bytes [LFSS_PATTERN_MAX];
  int          win_fill;
  logic        line_hit;
  logic [31:0] line_cnt;
  logic [31:0] sel_cnt;
  logic        stopped;

  lfss_result_t pending_reports [$];
  plan_row_t    plan [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  bit           cfg_open = 1'b0;
  int           idle_cycles = 0;

  function automatic lfss_result_t report(lfss_kind_t kind, logic [31:0] num, logic sel,
                                          logic [31:0] total, logic any, logic last);
    lfss_result_t r;
    r.kind           = kind;
    r.line_number    = num;
    r.selected       = sel;
    r.selected_total = total;
    r.any_selected   = any;
    r.last           = last;
    return r;
  endfunction

  function automatic logic [7:0] upper_fold(logic [7:0] c);
    if (cfg_icase && c >= "a" && c <= "z") begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(int i);
    return cfg_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic int active_len();
    return (cfg_len > LFSS_PATTERN_MAX) ? LFSS_PATTERN_MAX : int'(cfg_len);
  endfunction

  function automatic logic window_hit();
    int n;
    n = active_len();
    if (n == 0) begin
      return 1'b1;
    end
    if (win_fill < n) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (upper_fold(win_bytes[LFSS_PATTERN_MAX - n + i]) != upper_fold(pattern_at(i))) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < LFSS_PATTERN_MAX; i++) begin
      win_bytes[i] = 8'h00;
    end
    win_fill = 0;
    line_hit = 1'b0;
  endfunction

  // Judge the current line, bump the saturating counters, return the verdict
  function automatic logic judge_line();
    logic sel;
    sel = (line_hit || active_len() == 0) ^ cfg_invert;
    if (line_cnt != LFSS_COUNT_MAX) begin
      line_cnt++;
    end
    if (sel) begin
      if (sel_cnt != LFSS_COUNT_MAX) begin
        sel_cnt++;
      end
      if (cfg_stop) begin
        stopped = 1'b1;
      end
    end
    clear_window();
    return sel;
  endfunction

  function automatic void post(lfss_kind_t kind, logic [31:0] num, logic sel, logic last);
    pending_reports.push_back(report(kind, num, sel, sel_cnt, sel_cnt != 0, last));
  endfunction

  // Advance the line scanner by one transfer and queue the reports it causes
  function automatic logic scan_item(lfss_op_t op, logic [7:0] b);
    logic sel;
    if (op == LFSS_OP_TEXT) begin
      if (stopped) begin
        return 1'b1;
      end
      if (b == LFSS_NEWLINE) begin
        sel = judge_line();
        post(LFSS_KIND_VERDICT, line_cnt, sel, 1'b1);
        return 1'b0;
      end
      for (int i = 0; i < LFSS_PATTERN_MAX - 1; i++) begin
        win_bytes[i] = win_bytes[i + 1];
      end
      win_bytes[LFSS_PATTERN_MAX - 1] = b;
      if (win_fill < LFSS_PATTERN_MAX) begin
        win_fill++;
      end
      if (window_hit()) begin
        line_hit = 1'b1;
      end
      return 1'b0;
    end
    if (!stopped && win_fill != 0) begin
      sel = judge_line();
      post(LFSS_KIND_VERDICT, line_cnt, sel, 1'b0);
    end
    post(LFSS_KIND_SUMMARY, line_cnt, 1'b0, 1'b1);
    clear_window();
    line_cnt = '0;
    sel_cnt  = '0;
    stopped  = 1'b0;
    return 1'b0;
  endfunction

  function automatic plan_row_t cfg_row(lfss_reg_t r, logic [63:0] v);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = r;
    row.value   = v;
    return row;
  endfunction

  function automatic plan_row_t item_row(lfss_op_t op, logic [7:0] b);
    plan_row_t row;
    row        = '0;
    row.op     = op;
    row.text_b = b;
    return row;
  endfunction

  function automatic plan_row_t typed_row(lfss_op_t op, logic [7:0] b, lfss_result_t want);
    plan_row_t row;
    row       = item_row(op, b);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Hold off input until every report is out and the pipeline has drained
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(lfss_reg_t r, logic [63:0] v);
    if (!cfg_open) begin
      wait_idle();
      cfg_open = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      LFSS_REG_LENGTH: cfg_len = v[5:0];
      LFSS_REG_WORD_A: cfg_word[0] = v;
      LFSS_REG_WORD_B: cfg_word[1] = v;
      LFSS_REG_WORD_C: cfg_word[2] = v;
      LFSS_REG_WORD_D: cfg_word[3] = v;
      LFSS_REG_ICASE:  cfg_icase = v[0];
      LFSS_REG_INVERT: cfg_invert = v[0];
      LFSS_REG_STOP:   cfg_stop = v[0];
      default: ;
    endcase
  endtask

  // Send one input transfer in bursts with random gaps, then predict its reports
  task automatic send_item(lfss_op_t op, logic [7:0] b);
    int gap;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!scan_item(op, b)) begin
      items_sent++;
    end
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = 8'h00;
      1: c = 8'hFF;
      2: c = 8'($urandom_range(0, 255));
      default: begin
        c = 8'("a" + $urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) begin
          c = c - 8'h20;
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      default: begin
        for (int i = 0; i < 8; i++) begin
          w[i * 8 +: 8] = pick_pattern_byte();
        end
      end
    endcase
    return w;
  endfunction

  function automatic logic [5:0] pick_len();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4, 5: return 6'($urandom_range(2, 8));
      6: return 6'($urandom_range(9, 31));
      default: return 6'($urandom_range(33, 62));
    endcase
  endfunction

  // Line content that often shares bytes with the pattern, never a newline
  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if (active_len() > 0 && $urandom_range(0, 1) == 1) begin
      c = pattern_at($urandom_range(0, active_len() - 1));
    end else begin
      c = pick_pattern_byte();
    end
    return (c == LFSS_NEWLINE) ? "a" : c;
  endfunction

  task automatic random_config();
    set_reg(LFSS_REG_LENGTH, 64'(pick_len()));
    if ($urandom_range(0, 1) == 1) set_reg(LFSS_REG_WORD_A, pick_word());
    if ($urandom_range(0, 1) == 1) set_reg(LFSS_REG_WORD_B, pick_word());
    if ($urandom_range(0, 2) == 0) set_reg(LFSS_REG_WORD_C, pick_word());
    if ($urandom_range(0, 2) == 0) set_reg(LFSS_REG_WORD_D, pick_word());
    if ($urandom_range(0, 1) == 1) set_reg(LFSS_REG_ICASE, 64'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 1) set_reg(LFSS_REG_INVERT, 64'($urandom_range(0, 2) == 0));
    if ($urandom_range(0, 1) == 1) set_reg(LFSS_REG_STOP, 64'($urandom_range(0, 3) == 0));
  endtask

  // Send one line: noise, plain filler, or filler around a copy of the pattern
  task automatic send_line(bit terminate);
    int n;
    int pre;
    int post_len;
    int bad;
    logic [7:0] c;
    n = active_len();
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(0, 40)) send_item(LFSS_OP_TEXT, 8'($urandom_range(0, 255)));
      end
      1, 2, 3, 4, 5: begin
        pre = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        post_len = $urandom_range(0, 5);
        bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : -1;
        repeat (pre) send_item(LFSS_OP_TEXT, filler_byte());
        for (int i = 0; i < n; i++) begin
          c = pattern_at(i);
          if (cfg_icase && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
              && $urandom_range(0, 1) == 1) begin
            c = c ^ 8'h20;
          end
          if (i == bad) begin
            c = c + 8'd1;
          end
          send_item(LFSS_OP_TEXT, c);
        end
        repeat (post_len) send_item(LFSS_OP_TEXT, filler_byte());
      end
      default: begin
        repeat ($urandom_range(0, 12)) send_item(LFSS_OP_TEXT, filler_byte());
      end
    endcase
    if (terminate) begin
      send_item(LFSS_OP_TEXT, LFSS_NEWLINE);
    end
  endtask

  // Receiver: switch between always ready, random stalls and long on/off stretches
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 2);
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold_left == 0) begin
          m_tready     <= !m_tready;
          rx_hold_left <= $urandom_range(1, 12);
        end else begin
          rx_hold_left <= rx_hold_left - 1;
        end
      end
    endcase
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest queued report
  lfss_result_t head;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result with nothing pending: kind %0d line %0d", m_tuser, m_tdata[31:0]);
        mismatches++;
      end else begin
        head = pending_reports.pop_front();
        check_field("kind", 32'(head.kind), 32'(m_tuser));
        check_field("line_number", head.line_number, m_tdata[31:0]);
        check_field("selected", 32'(head.selected), 32'(m_tdata[32]));
        check_field("selected_total", head.selected_total, m_tdata[64:33]);
        check_field("any_selected", 32'(head.any_selected), 32'(m_tdata[65]));
        check_field("last", 32'(head.last), 32'(m_tlast));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int nlines;
    cfg_len    = '0;
    cfg_icase  = 1'b0;
    cfg_invert = 1'b0;
    cfg_stop   = 1'b0;
    for (int i = 0; i < LFSS_WORDS; i++) begin
      cfg_word[i] = '0;
    end
    clear_window();
    line_cnt = '0;
    sel_cnt  = '0;
    stopped  = 1'b0;

    // Empty pattern after reset: empty stream, empty line, zero and all-ones bytes
    plan.push_back(typed_row(LFSS_OP_END, 8'h00,
                             report(LFSS_KIND_SUMMARY, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1)));
    plan.push_back(typed_row(LFSS_OP_TEXT, LFSS_NEWLINE,
                             report(LFSS_KIND_VERDICT, 32'd1, 1'b1, 32'd1, 1'b1, 1'b1)));
    plan.push_back(item_row(LFSS_OP_TEXT, 8'h00));
    plan.push_back(item_row(LFSS_OP_TEXT, 8'hFF));
    // Unterminated final line: verdict then summary
    plan.push_back(item_row(LFSS_OP_END, 8'hA5));
    // Case-folded match
    plan.push_back(cfg_row(LFSS_REG_LENGTH, 64'd3));
    plan.push_back(cfg_row(LFSS_REG_WORD_A, 64'h636261));
    plan.push_back(cfg_row(LFSS_REG_ICASE, 64'd1));
    plan.push_back(item_row(LFSS_OP_TEXT, "x"));
    plan.push_back(item_row(LFSS_OP_TEXT, "A"));
    plan.push_back(item_row(LFSS_OP_TEXT, "b"));
    plan.push_back(item_row(LFSS_OP_TEXT, "C"));
    plan.push_back(item_row(LFSS_OP_TEXT, LFSS_NEWLINE));
    // Inverted selection with stop on first: later bytes are dropped
    plan.push_back(cfg_row(LFSS_REG_INVERT, 64'd1));
    plan.push_back(cfg_row(LFSS_REG_STOP, 64'd1));
    plan.push_back(typed_row(LFSS_OP_TEXT, LFSS_NEWLINE,
                             report(LFSS_KIND_VERDICT, 32'd2, 1'b1, 32'd2, 1'b1, 1'b1)));
    plan.push_back(item_row(LFSS_OP_TEXT, "a"));
    plan.push_back(item_row(LFSS_OP_TEXT, LFSS_NEWLINE));
    plan.push_back(typed_row(LFSS_OP_END, 8'hFF,
                             report(LFSS_KIND_SUMMARY, 32'd2, 1'b0, 32'd2, 1'b1, 1'b1)));
    // Zero byte as a pattern byte
    plan.push_back(cfg_row(LFSS_REG_LENGTH, 64'd1));
    plan.push_back(cfg_row(LFSS_REG_WORD_A, 64'd0));
    plan.push_back(cfg_row(LFSS_REG_ICASE, 64'd0));
    plan.push_back(cfg_row(LFSS_REG_INVERT, 64'd0));
    plan.push_back(cfg_row(LFSS_REG_STOP, 64'd0));
    plan.push_back(item_row(LFSS_OP_TEXT, 8'h00));
    plan.push_back(item_row(LFSS_OP_TEXT, LFSS_NEWLINE));
    plan.push_back(item_row(LFSS_OP_TEXT, "a"));
    plan.push_back(item_row(LFSS_OP_END, 8'h00));
    // Oversized length is clamped; a length change mid-line applies to the rest
    plan.push_back(cfg_row(LFSS_REG_WORD_B, '1));
    plan.push_back(cfg_row(LFSS_REG_WORD_C, 64'h8000_0000_0000_0001));
    plan.push_back(cfg_row(LFSS_REG_WORD_D, 64'h0123_4567_89AB_CDEF));
    plan.push_back(cfg_row(LFSS_REG_LENGTH, 64'd63));
    plan.push_back(item_row(LFSS_OP_TEXT, "q"));
    plan.push_back(cfg_row(LFSS_REG_LENGTH, 64'd0));
    plan.push_back(item_row(LFSS_OP_TEXT, LFSS_NEWLINE));
    plan.push_back(item_row(LFSS_OP_END, 8'h5A));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_item(plan[i].op, plan[i].text_b);
        if (plan[i].typed) begin
          void'(pending_reports.pop_back());
          pending_reports.push_back(plan[i].want);
        end
      end
    end

    // Random phases: new settings, a few lines, usually an end of input
    items_sent = 0;
    while (items_sent < ITEM_GOAL) begin
      random_config();
      nlines = $urandom_range(1, 10);
      for (int l = 0; l < nlines; l++) begin
        send_line(l != nlines - 1 || $urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_item(LFSS_OP_END, 8'($urandom_range(0, 255)));
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
